// ----- sv/pae_pkg.sv -----
`default_nettype none

package pae_pkg;

    // Stream field widths (fixed by the interface).
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // tdata widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_PAD_W    = IN_TDATA_W - INDEX_W - VALUE_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - COUNT_W;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ----- sv/pae_mem.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one read port, registered read data.
module pae_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output      logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/pae_seq.sv -----
`default_nettype none

// Operation sequencer: owns the count, walks the RAM one word per cycle
// for insert/erase shifts.
module pae_seq #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request
    input  wire logic                          i_req_valid,
    output      logic                          o_req_ready,
    input  wire logic [pae_pkg::FUNC_W-1:0]    i_req_func,
    input  wire logic [pae_pkg::INDEX_W-1:0]   i_req_index,
    input  wire logic [pae_pkg::VALUE_W-1:0]   i_req_value,
    // result
    output      logic                          o_res_valid,
    input  wire logic                          i_res_ready,
    output      logic [DATA_WIDTH-1:0]         o_res_value,
    output      logic [CNT_W-1:0]              o_res_count,
    output      pae_pkg::t_status              o_res_status,
    // RAM port
    output      logic                          o_mem_we,
    output      logic [AW-1:0]                 o_mem_waddr,
    output      logic [DATA_WIDTH-1:0]         o_mem_wdata,
    output      logic                          o_mem_re,
    output      logic [AW-1:0]                 o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]         i_mem_rdata
);

    // index compare width: wide enough for both the index field and the count
    localparam int CMP_W = (CNT_W > pae_pkg::INDEX_W) ? CNT_W : pae_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INS,
        S_INS_FIN,
        S_ERS_HEAD,
        S_ERS,
        S_RESP
    } t_state;

    t_state                r_state,      n_state;
    logic [CNT_W-1:0]      r_count,      n_count;
    logic [AW-1:0]         r_ptr,        n_ptr;
    logic [AW-1:0]         r_pos,        n_pos;
    logic [DATA_WIDTH-1:0] r_word,       n_word;
    logic [DATA_WIDTH-1:0] r_res_value,  n_res_value;
    pae_pkg::t_status      r_res_status, n_res_status;

    logic [DATA_WIDTH-1:0] w_word;
    logic [CMP_W-1:0]      w_pos_ext;
    logic [CMP_W-1:0]      w_cnt_ext;
    logic                  w_full;
    logic                  w_empty;

    assign w_word    = DATA_WIDTH'(i_req_value);
    assign w_pos_ext = CMP_W'(i_req_index);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_pos        = r_pos;
        n_word       = r_word;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_ptr;
        o_mem_wdata  = i_mem_rdata;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res_value  = '0;
                    n_res_status = pae_pkg::ST_OK;
                    n_state      = S_RESP;
                    n_pos        = AW'(i_req_index);
                    n_word       = w_word;
                    case (i_req_func)
                        pae_pkg::FUNC_PUSH: begin
                            if (w_full) begin
                                n_res_status = pae_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = w_word;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        pae_pkg::FUNC_POP: begin
                            if (w_empty) begin
                                n_res_status = pae_pkg::ST_EMPTY;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_count - CNT_W'(1));
                                n_count     = r_count - CNT_W'(1);
                                n_state     = S_RD_WAIT;
                            end
                        end
                        pae_pkg::FUNC_INSERT: begin
                            if (w_full) begin
                                n_res_status = pae_pkg::ST_FULL;
                            end else if (w_pos_ext > w_cnt_ext) begin
                                n_res_status = pae_pkg::ST_BAD_INDEX;
                            end else if (w_pos_ext == w_cnt_ext) begin
                                // append at the end, nothing to move
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(i_req_index);
                                o_mem_wdata = w_word;
                                n_count     = r_count + CNT_W'(1);
                            end else begin
                                // start moving the tail up from the last word
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_count - CNT_W'(1));
                                n_ptr       = AW'(r_count - CNT_W'(1));
                                n_state     = S_INS;
                            end
                        end
                        pae_pkg::FUNC_ERASE: begin
                            if (w_empty) begin
                                n_res_status = pae_pkg::ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_res_status = pae_pkg::ST_BAD_INDEX;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(i_req_index);
                                n_state     = S_ERS_HEAD;
                            end
                        end
                        pae_pkg::FUNC_READ: begin
                            if (w_empty) begin
                                n_res_status = pae_pkg::ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_res_status = pae_pkg::ST_BAD_INDEX;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(i_req_index);
                                n_state     = S_RD_WAIT;
                            end
                        end
                        default: begin
                            // unknown code: no change, ok status
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_res_value = i_mem_rdata;
                n_state     = S_RESP;
            end
            S_INS: begin
                // rdata is word r_ptr, it moves to r_ptr + 1
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr + AW'(1);
                o_mem_wdata = i_mem_rdata;
                if (r_ptr == r_pos) begin
                    n_state = S_INS_FIN;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr - AW'(1);
                    n_ptr       = r_ptr - AW'(1);
                end
            end
            S_INS_FIN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_word;
                n_count     = r_count + CNT_W'(1);
                n_state     = S_RESP;
            end
            S_ERS_HEAD: begin
                n_res_value = i_mem_rdata;
                if ((CNT_W'(r_pos) + CNT_W'(1)) < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_pos + AW'(1);
                    n_ptr       = r_pos + AW'(1);
                    n_state     = S_ERS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_ERS: begin
                // rdata is word r_ptr, it moves to r_ptr - 1
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr - AW'(1);
                o_mem_wdata = i_mem_rdata;
                if ((CNT_W'(r_ptr) + CNT_W'(1)) < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_ptr        <= n_ptr;
        r_pos        <= n_pos;
        r_word       <= n_word;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_RESP);
    assign o_res_value  = r_res_value;
    assign o_res_count  = r_count;
    assign o_res_status = r_res_status;

endmodule

`default_nettype wire

// ----- sv/positional_array_insert_erase.sv -----
// Sequence: push, full/empty/bad-index and unknown codes go straight to the result state;
//   pop and read wait for the RAM read; insert and erase move one RAM word per cycle.
// Flow: one transaction in the sequencer at a time; a new request is accepted only
//   after the sequencer has handed the last result to the output register.
// Reset: synchronous, active low; clears the count and the handshake state.
//   The word RAM is not cleared (no clearing pass); only written entries are read.
`default_nettype none

module positional_array_insert_erase #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request stream
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    // [3:0] index, [35:4] value, [39:36] zero pad
    input  wire logic [pae_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [2:0] func
    input  wire logic [pae_pkg::FUNC_W-1:0]         i_s_tuser,
    // result stream
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [31:0] read_value, [36:32] count, [39:37] zero pad
    output      logic [pae_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [1:0] status
    output      logic [pae_pkg::STATUS_W-1:0]       o_m_tuser
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer <-> RAM
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [DATA_WIDTH-1:0] w_mem_wdata;
    logic                  w_mem_re;
    logic [AW-1:0]         w_mem_raddr;
    logic [DATA_WIDTH-1:0] w_mem_rdata;

    // sequencer -> output stage
    logic                  w_res_valid;
    logic                  w_res_ready;
    logic [DATA_WIDTH-1:0] w_res_value;
    logic [CNT_W-1:0]      w_res_count;
    pae_pkg::t_status      w_res_status;

    // output register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [CNT_W-1:0]      r_out_count;
    pae_pkg::t_status      r_out_status;
    logic [63:0]           w_out_value_ext;

    pae_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    pae_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_req_func   (i_s_tuser),
        .i_req_index  (i_s_tdata[pae_pkg::INDEX_W-1:0]),
        .i_req_value  (i_s_tdata[pae_pkg::INDEX_W +: pae_pkg::VALUE_W]),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res_value  (w_res_value),
        .o_res_count  (w_res_count),
        .o_res_status (w_res_status),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    // Output register: the sequencer hands off its result and goes back to
    // taking requests while the downstream side may still be stalled.
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_valid && w_res_ready) begin
            r_out_value  <= w_res_value;
            r_out_count  <= w_res_count;
            r_out_status <= w_res_status;
        end
    end

    // word zero-extended or truncated to the 32-bit field
    assign w_out_value_ext = 64'(r_out_value);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{pae_pkg::OUT_PAD_W{1'b0}},
                         pae_pkg::COUNT_W'(r_out_count),
                         w_out_value_ext[pae_pkg::VALUE_W-1:0]};
    assign o_m_tuser  = r_out_status;

    // full is only reported with the array at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == pae_pkg::ST_FULL))
            |-> (r_out_count == CNT_W'(DEPTH)))
        else $error("full status with count below capacity");

    // empty is only reported with no stored words
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == pae_pkg::ST_EMPTY))
            |-> (r_out_count == '0))
        else $error("empty status with nonzero count");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= CNT_W'(DEPTH)))
        else $error("count above capacity");

    // one request at a time: the sequencer is busy right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while previous one in flight");

endmodule

`default_nettype wire
